// ===== src/mwr_pkg.sv =====
// ============================================================================
// mwr_pkg
// Shared sizes, payload types and the sine table for the morphing wavetable
// read block.
// ============================================================================
package mwr_pkg;

    // Bank geometry. FRAME_LENGTH must be a power of two (16 to 65536).
    localparam int FRAME_COUNT  = 64;
    localparam int FRAME_LENGTH = 2048;

    localparam int SAMPLE_W = 18;
    localparam int PHASE_W  = 32;
    localparam int FPOS_W   = 16;
    localparam int FT_W     = 10;
    localparam int WARP_W   = 16;
    localparam int WFRAME_W = 6;
    localparam int WINDEX_W = 11;
    localparam int IT_W     = 16;

    localparam int FRAME_W    = $clog2(FRAME_COUNT);
    localparam int IDX_W      = $clog2(FRAME_LENGTH);
    localparam int COL_W      = IDX_W - 1;
    localparam int BANK_ROWS  = (FRAME_COUNT + 1) / 2;
    localparam int ROW_W      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
    localparam int BANK_AW    = ROW_W + COL_W;
    localparam int BANK_DEPTH = BANK_ROWS * (FRAME_LENGTH / 2);
    localparam int BANKS      = 4;

    // Highest frame position: just below the last frame.
    localparam int FPOS_LIMIT = (FRAME_COUNT - 1) * (2 ** FT_W) - 1;

    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);

    typedef enum logic
    {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } command_t;

    typedef logic        [PHASE_W-1:0]  phase_t;
    typedef logic        [FPOS_W-1:0]   fpos_t;
    typedef logic signed [WARP_W-1:0]   warp_t;
    typedef logic        [WFRAME_W-1:0] wframe_t;
    typedef logic        [WINDEX_W-1:0] windex_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [FT_W-1:0]     ft_t;
    typedef logic        [IT_W-1:0]     it_t;
    typedef logic        [FRAME_W-1:0]  frame_t;
    typedef logic        [ROW_W-1:0]    row_t;
    typedef logic        [COL_W-1:0]    col_t;
    typedef logic        [BANK_AW-1:0]  bank_addr_t;
    typedef logic        [1:0]          bank_sel_t;
    typedef logic signed [15:0]         sine_t;
    typedef sine_t                      sine_rom_t [SINE_DEPTH];

    localparam fpos_t FPOS_MAX = (FPOS_LIMIT > 65535) ? 16'hFFFF : fpos_t'(FPOS_LIMIT);

    // Quarter-wave polynomial, Q1.15, for step r of 256.
    function automatic longint quarter_sine(input longint r);
        longint x;
        longint x2;
        longint t;
        longint y;
        x  = r * 256;
        x2 = (x * x) >>> 16;
        t  = (4640 * x2) >>> 16;
        t  = 42048 - t;
        t  = (t * x2) >>> 16;
        t  = 102944 - t;
        y  = (t * x) >>> 16;
        return (y * 32767 + 32768) >>> 16;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    q;
        longint    r;
        longint    m;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            q = k / 256;
            r = k % 256;
            m = (q % 2 == 1) ? quarter_sine(256 - r) : quarter_sine(r);
            if (q >= 2)
                m = -m;
            rom[k] = sine_t'(m);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== src/mwr_if.sv =====
// ============================================================================
// mwr_in_if / mwr_out_if
// Valid/ready channels of the morphing wavetable read block: command items
// in, interpolated samples out.
// ============================================================================
interface mwr_in_if;
    logic              valid;
    logic              ready;
    mwr_pkg::command_t command;
    mwr_pkg::phase_t   phase;
    mwr_pkg::fpos_t    frame_position;
    mwr_pkg::warp_t    warp;
    mwr_pkg::wframe_t  write_frame;
    mwr_pkg::windex_t  write_index;
    mwr_pkg::sample_t  write_value;

    modport source
    (
        output valid, command, phase, frame_position, warp,
               write_frame, write_index, write_value,
        input  ready
    );

    modport sink
    (
        input  valid, command, phase, frame_position, warp,
               write_frame, write_index, write_value,
        output ready
    );
endinterface

interface mwr_out_if;
    logic             valid;
    logic             ready;
    mwr_pkg::sample_t sample;

    modport source
    (
        output valid, sample,
        input  ready
    );

    modport sink
    (
        input  valid, sample,
        output ready
    );
endinterface

// ===== src/morphing_wavetable_read.sv =====
// ============================================================================
// morphing_wavetable_read
// Wave frame bank with single-sample writes and warped, bilinearly
// interpolated reads.
// ============================================================================
// Usage:
//   in_ch carries one item per valid/ready handshake. A write item
//   (command = CMD_WRITE) stores write_value at write_frame/write_index and
//   gives no result; writes outside the bank are dropped. A read item gives
//   one sample on out_ch.
//   Nine register stages: sine lookup, warp multiply, phase add, address
//   split, bank read, two lerp stages along the phase, two between frames.
//   A read's sample is registered through every stage to out_ch. One item
//   is taken every cycle unless out_ch stalls; the bank is split into four
//   single-port read banks (frame parity x index parity) so all four
//   neighbours of a read come out in the same cycle alongside one write.
//   Each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so a stalled receiver fills the bubbles before
//   in_ch.ready falls; nothing is dropped or repeated.
//   Reset empties the pipeline. The bank contents are not cleared: every
//   entry must be written before it is read.
// ============================================================================
module morphing_wavetable_read
(
    input  logic      clk,
    input  logic      rst_n,
    mwr_in_if.sink    in_ch,
    mwr_out_if.source out_ch
);
    import mwr_pkg::*;

    typedef struct packed
    {
        command_t   cmd;
        logic       wr_ok;
        bank_sel_t  wr_bank;
        bank_addr_t wr_addr;
        sample_t    wr_data;
        ft_t        ft;
    } carry_t;

    localparam int STAGES = 9;

    logic [STAGES:1] vld_reg;
    logic [STAGES:1] vld_next;
    logic [STAGES:1] vld_in;
    logic [STAGES:1] rdy;

    // Stage 1
    carry_t  s1_carry_reg;
    phase_t  s1_phase_reg;
    warp_t   s1_warp_reg;
    sine_t   s1_sine_reg;
    frame_t  s1_a_reg;
    carry_t  s1_carry_next;
    fpos_t   fp_clamped;

    // Stage 2
    carry_t              s2_carry_reg;
    phase_t              s2_phase_reg;
    frame_t              s2_a_reg;
    logic signed [31:0]  s2_delta_reg;
    logic signed [31:0]  s2_delta_next;

    // Stage 3
    carry_t  s3_carry_reg;
    phase_t  s3_ph_reg;
    frame_t  s3_a_reg;
    phase_t  s3_ph_next;

    // Stage 4
    carry_t     s4_carry_reg;
    bank_addr_t s4_addr_reg [BANKS];
    bank_addr_t s4_addr_next [BANKS];
    logic       s4_a0_reg;
    logic       s4_i0p_reg;
    it_t        s4_it_reg;
    logic [IDX_W-1:0] i0;
    col_t       col_odd;
    col_t       col_even;
    row_t       row_odd;
    row_t       row_even;
    logic       wr_en;

    // Stage 5
    sample_t s5_data [BANKS];
    logic    s5_a0_reg;
    logic    s5_i0p_reg;
    it_t     s5_it_reg;
    ft_t     s5_ft_reg;

    // Stage 6
    sample_t             xa;
    sample_t             ya;
    sample_t             xb;
    sample_t             yb;
    logic signed [18:0]  da;
    logic signed [18:0]  db;
    logic signed [35:0]  s6_pa_next;
    logic signed [35:0]  s6_pb_next;
    logic signed [35:0]  s6_pa_reg;
    logic signed [35:0]  s6_pb_reg;
    sample_t             s6_xa_reg;
    sample_t             s6_xb_reg;
    ft_t                 s6_ft_reg;

    // Stage 7
    logic signed [35:0]  pa_rnd;
    logic signed [35:0]  pb_rnd;
    sample_t             s7_va_next;
    sample_t             s7_vb_next;
    sample_t             s7_va_reg;
    sample_t             s7_vb_reg;
    ft_t                 s7_ft_reg;

    // Stage 8
    logic signed [18:0]  dv;
    logic signed [29:0]  s8_pv_next;
    logic signed [29:0]  s8_pv_reg;
    sample_t             s8_va_reg;

    // Stage 9 (output register)
    logic signed [29:0]  pv_rnd;
    logic signed [18:0]  v_full;
    sample_t             s9_sample_next;
    sample_t             s9_sample_reg;

    // ------------------------------------------------------------------
    // Handshake: each stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    always_comb
    begin
        rdy[STAGES] = ~vld_reg[STAGES] | out_ch.ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
        for (int k = 1; k <= STAGES; k++)
        begin
            if (k == 1)
                vld_in[k] = in_ch.valid;
            else
                vld_in[k] = vld_reg[k-1];
        end
        // Write items end at the bank stage.
        vld_in[5] = vld_reg[4] & (s4_carry_reg.cmd == CMD_READ);
        for (int k = 1; k <= STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ch.ready  = rdy[1];
    assign out_ch.valid = vld_reg[STAGES];
    assign out_ch.sample = s9_sample_reg;

    // ------------------------------------------------------------------
    // Stage 1: sine lookup, frame clamp, write decode
    // ------------------------------------------------------------------
    assign fp_clamped = (in_ch.frame_position > FPOS_MAX) ? FPOS_MAX : in_ch.frame_position;

    always_comb
    begin
        s1_carry_next.cmd     = in_ch.command;
        s1_carry_next.wr_ok   = (int'(in_ch.write_frame) < FRAME_COUNT)
                              && (int'(in_ch.write_index) < FRAME_LENGTH);
        s1_carry_next.wr_bank = {in_ch.write_frame[0], in_ch.write_index[0]};
        s1_carry_next.wr_addr = {row_t'(in_ch.write_frame >> 1),
                                 col_t'(in_ch.write_index >> 1)};
        s1_carry_next.wr_data = in_ch.write_value;
        s1_carry_next.ft      = fp_clamped[FT_W-1:0];
    end

    // Stage 2: warp times sine
    assign s2_delta_next = 32'(s1_warp_reg) * 32'(s1_sine_reg);

    // Stage 3: warped phase, Q3.29 delta scaled to cycles, wraps
    assign s3_ph_next = s2_phase_reg + {s2_delta_reg[PHASE_W-4:0], 3'b000};

    // ------------------------------------------------------------------
    // Stage 4: split phase into index and fraction, bank addresses.
    // Frames a and a+1 and indices i0 and i0+1 always differ in parity,
    // so each neighbour lands in a bank of its own.
    // ------------------------------------------------------------------
    assign i0       = s3_ph_reg[PHASE_W-1 -: IDX_W];
    assign col_odd  = col_t'(i0 >> 1);
    assign col_even = i0[0] ? col_odd + col_t'(1) : col_odd;
    assign row_odd  = row_t'(s3_a_reg >> 1);
    assign row_even = s3_a_reg[0] ? row_odd + row_t'(1) : row_odd;

    always_comb
    begin
        for (int g = 0; g < BANKS; g++)
        begin
            s4_addr_next[g] = {(g / 2 == 1) ? row_odd : row_even,
                               (g % 2 == 1) ? col_odd : col_even};
        end
    end

    assign wr_en = rdy[5] && vld_reg[4] && (s4_carry_reg.cmd == CMD_WRITE)
                && s4_carry_reg.wr_ok;

    // ------------------------------------------------------------------
    // Stage 5: four banks, indexed by {frame parity, index parity}
    // ------------------------------------------------------------------
    for (genvar g = 0; g < BANKS; g++)
    begin : g_bank
        sample_t bank_mem [BANK_DEPTH];
        sample_t rd_data_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (s4_carry_reg.wr_bank == bank_sel_t'(g)))
                bank_mem[s4_carry_reg.wr_addr] <= s4_carry_reg.wr_data;
            if (rdy[5])
                rd_data_reg <= bank_mem[s4_addr_reg[g]];
        end

        assign s5_data[g] = rd_data_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: route bank outputs to neighbours, difference times fraction
    // ------------------------------------------------------------------
    always_comb
    begin
        xa = s5_a0_reg ? (s5_i0p_reg ? s5_data[3] : s5_data[2])
                       : (s5_i0p_reg ? s5_data[1] : s5_data[0]);
        ya = s5_a0_reg ? (s5_i0p_reg ? s5_data[2] : s5_data[3])
                       : (s5_i0p_reg ? s5_data[0] : s5_data[1]);
        xb = s5_a0_reg ? (s5_i0p_reg ? s5_data[1] : s5_data[0])
                       : (s5_i0p_reg ? s5_data[3] : s5_data[2]);
        yb = s5_a0_reg ? (s5_i0p_reg ? s5_data[0] : s5_data[1])
                       : (s5_i0p_reg ? s5_data[2] : s5_data[3]);
    end

    assign da = {ya[SAMPLE_W-1], ya} - {xa[SAMPLE_W-1], xa};
    assign db = {yb[SAMPLE_W-1], yb} - {xb[SAMPLE_W-1], xb};
    assign s6_pa_next = 36'(da) * 36'($signed({1'b0, s5_it_reg}));
    assign s6_pb_next = 36'(db) * 36'($signed({1'b0, s5_it_reg}));

    // Stage 7: round half up and add back the base sample
    assign pa_rnd = (s6_pa_reg + 36'sd32768) >>> IT_W;
    assign pb_rnd = (s6_pb_reg + 36'sd32768) >>> IT_W;
    assign s7_va_next = s6_xa_reg + $signed(pa_rnd[SAMPLE_W-1:0]);
    assign s7_vb_next = s6_xb_reg + $signed(pb_rnd[SAMPLE_W-1:0]);

    // Stage 8: frame difference times frame fraction
    assign dv = {s7_vb_reg[SAMPLE_W-1], s7_vb_reg} - {s7_va_reg[SAMPLE_W-1], s7_va_reg};
    assign s8_pv_next = 30'(dv) * 30'($signed({1'b0, s7_ft_reg}));

    // Stage 9: round, add, saturate
    assign pv_rnd = (s8_pv_reg + 30'sd512) >>> FT_W;
    assign v_full = {s8_va_reg[SAMPLE_W-1], s8_va_reg} + pv_rnd[SAMPLE_W:0];

    always_comb
    begin
        if (v_full[SAMPLE_W] != v_full[SAMPLE_W-1])
            s9_sample_next = v_full[SAMPLE_W] ? sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}})
                                              : sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
        else
            s9_sample_next = v_full[SAMPLE_W-1:0];
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_carry_reg <= s1_carry_next;
            s1_phase_reg <= in_ch.phase;
            s1_warp_reg  <= in_ch.warp;
            s1_sine_reg  <= SINE_ROM[in_ch.phase[PHASE_W-1 -: SINE_AW]];
            s1_a_reg     <= frame_t'(fp_clamped >> FT_W);
        end
        if (rdy[2])
        begin
            s2_carry_reg <= s1_carry_reg;
            s2_phase_reg <= s1_phase_reg;
            s2_a_reg     <= s1_a_reg;
            s2_delta_reg <= s2_delta_next;
        end
        if (rdy[3])
        begin
            s3_carry_reg <= s2_carry_reg;
            s3_ph_reg    <= s3_ph_next;
            s3_a_reg     <= s2_a_reg;
        end
        if (rdy[4])
        begin
            s4_carry_reg <= s3_carry_reg;
            s4_addr_reg  <= s4_addr_next;
            s4_a0_reg    <= s3_a_reg[0];
            s4_i0p_reg   <= i0[0];
            s4_it_reg    <= s3_ph_reg[PHASE_W-1-IDX_W -: IT_W];
        end
        if (rdy[5])
        begin
            s5_a0_reg  <= s4_a0_reg;
            s5_i0p_reg <= s4_i0p_reg;
            s5_it_reg  <= s4_it_reg;
            s5_ft_reg  <= s4_carry_reg.ft;
        end
        if (rdy[6])
        begin
            s6_pa_reg <= s6_pa_next;
            s6_pb_reg <= s6_pb_next;
            s6_xa_reg <= xa;
            s6_xb_reg <= xb;
            s6_ft_reg <= s5_ft_reg;
        end
        if (rdy[7])
        begin
            s7_va_reg <= s7_va_next;
            s7_vb_reg <= s7_vb_next;
            s7_ft_reg <= s6_ft_reg;
        end
        if (rdy[8])
        begin
            s8_pv_reg <= s8_pv_next;
            s8_va_reg <= s7_va_reg;
        end
        if (rdy[9])
        begin
            s9_sample_reg <= s9_sample_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A write item must leave no result behind it.
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !vld_reg[5])
        else $error("write item reached the interpolation stages");

    // Even-parity neighbours sit at the same or the next row and column.
    a_bank_neighbours: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[4] && (s4_carry_reg.cmd == CMD_READ)) |->
        (((s4_addr_reg[0][BANK_AW-1 -: ROW_W] == s4_addr_reg[2][BANK_AW-1 -: ROW_W])
          || (s4_addr_reg[0][BANK_AW-1 -: ROW_W]
              == s4_addr_reg[2][BANK_AW-1 -: ROW_W] + row_t'(1)))
         && ((s4_addr_reg[0][COL_W-1:0] == s4_addr_reg[1][COL_W-1:0])
          || (s4_addr_reg[0][COL_W-1:0] == s4_addr_reg[1][COL_W-1:0] + col_t'(1)))))
        else $error("bank read addresses are not neighbours");

    // Interpolation between in-range samples never needs saturation.
    a_lerp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] |-> (v_full[SAMPLE_W] == v_full[SAMPLE_W-1]))
        else $error("frame interpolation left the sample range");

endmodule

// ===== verif/morphing_wavetable_read_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// morphing_wavetable_read_tb
// Self-checking bench for the morphing wavetable read block. A directed table
// covers bank corners, frame clamping, phase wrap and warp extremes. Random
// oscillator sweeps, lone reads and stray writes follow under three pacing
// mixes and one long output hold-off. Every sample is checked against a
// tabled value or an in-bench bank copy and interpolation predictor. No read
// touches an entry that has not been written first.
// ============================================================================
module morphing_wavetable_read_tb;
    import mwr_pkg::*;

    localparam int          BANK_SIZE    = FRAME_COUNT * FRAME_LENGTH;
    localparam int unsigned FPOS_CLAMP   = (FRAME_COUNT - 1) * 1024 - 1;
    localparam longint      SAMPLE_HIGH  = 131071;
    localparam longint      SAMPLE_LOW   = -131072;
    localparam sample_t     SAMPLE_TOP   = 18'sh1FFFF;
    localparam sample_t     SAMPLE_FLOOR = 18'sh20000;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          MODE_ITEMS   = 370;

    typedef struct {
        int unsigned addr [4];
        longint      it;
        longint      ft;
    } taps_t;

    typedef struct {
        command_t cmd;
        phase_t   ph;
        fpos_t    fp;
        warp_t    wp;
        wframe_t  wf;
        windex_t  wi;
        sample_t  wv;
        bit       known;
        sample_t  want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mwr_in_if  in_bus ();
    mwr_out_if out_bus ();

    morphing_wavetable_read dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    sample_t   bank_copy    [BANK_SIZE];
    bit        bank_written [BANK_SIZE];
    sample_t   expected_samples [$];
    stim_row_t directed_rows [$];
    taps_t     last_taps;

    int src_idle_pct    = 0;
    int snk_idle_pct    = 0;
    bit hold_request    = 1'b0;
    int failures        = 0;
    int samples_checked = 0;
    int writes_done     = 0;
    int fills_done      = 0;
    int reads_done      = 0;
    int items_done      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Quarter-wave polynomial folded into a full cycle, Q1.15.
    function automatic longint sine_sample(input logic [9:0] k);
        longint r;
        longint x;
        longint x2;
        longint t;
        longint y;
        longint m;
        r  = k[8] ? 256 - longint'(k[7:0]) : longint'(k[7:0]);
        x  = r << 8;
        x2 = (x * x) >> 16;
        t  = 42048 - ((4640 * x2) >> 16);
        t  = 102944 - ((t * x2) >> 16);
        y  = (t * x) >> 16;
        m  = (y * 32767 + 32768) >> 16;
        return k[9] ? -m : m;
    endfunction

    // Rounds half up; the arithmetic shift gives the floor.
    function automatic longint blend(input longint x, input longint y, input longint f,
                                     input int n);
        return (x * ((longint'(1) << n) - f) + y * f + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic taps_t locate_taps(input phase_t phase_in, input fpos_t fpos_in,
                                          input warp_t warp_in);
        taps_t       t;
        longint      shift;
        phase_t      warped;
        logic [63:0] pos;
        int unsigned fp;
        int unsigned fa;
        int unsigned fb;
        int unsigned i0;
        int unsigned i1;
        shift  = longint'(warp_in) * sine_sample(phase_in[31:22]) * 8;
        warped = phase_in + shift[31:0];
        fp     = (fpos_in > FPOS_CLAMP) ? FPOS_CLAMP : int'(fpos_in);
        fa     = fp >> FT_W;
        fb     = fa + 1;
        pos    = {32'b0, warped} * 64'(FRAME_LENGTH);
        i0     = pos[63:32];
        i1     = (i0 + 1 == FRAME_LENGTH) ? 0 : i0 + 1;
        t.it   = longint'(pos[31:16]);
        t.ft   = longint'(fp % 1024);
        t.addr[0] = fa * FRAME_LENGTH + i0;
        t.addr[1] = fa * FRAME_LENGTH + i1;
        t.addr[2] = fb * FRAME_LENGTH + i0;
        t.addr[3] = fb * FRAME_LENGTH + i1;
        return t;
    endfunction

    function automatic sample_t predict_sample(input taps_t t);
        longint va;
        longint vb;
        longint v;
        va = blend(bank_copy[t.addr[0]], bank_copy[t.addr[1]], t.it, 16);
        vb = blend(bank_copy[t.addr[2]], bank_copy[t.addr[3]], t.it, 16);
        v  = blend(va, vb, t.ft, 10);
        if (v > SAMPLE_HIGH)
            v = SAMPLE_HIGH;
        if (v < SAMPLE_LOW)
            v = SAMPLE_LOW;
        return sample_t'(v);
    endfunction

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return SAMPLE_TOP;
        else if (pick == 1)
            return SAMPLE_FLOOR;
        return sample_t'($urandom);
    endfunction

    function automatic stim_row_t write_row(input int f, input int i, input int v);
        stim_row_t r;
        r = '{CMD_WRITE, '0, '0, '0, wframe_t'(f), windex_t'(i), sample_t'(v), 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t read_row(input phase_t ph, input fpos_t fp, input warp_t wp,
                                           input bit known, input int want);
        stim_row_t r;
        r = '{CMD_READ, ph, fp, wp, '0, '0, '0, known, sample_t'(want)};
        return r;
    endfunction

    // Offer one item, hold it until taken, then update the bank copy or queue
    // the predicted sample.
    task automatic push_item(input stim_row_t r);
        int unsigned waddr;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.command        <= r.cmd;
        in_bus.phase          <= r.ph;
        in_bus.frame_position <= r.fp;
        in_bus.warp           <= r.wp;
        in_bus.write_frame    <= r.wf;
        in_bus.write_index    <= r.wi;
        in_bus.write_value    <= r.wv;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
        items_done++;
        if (r.cmd == CMD_WRITE)
        begin
            writes_done++;
            if (r.wf < FRAME_COUNT && r.wi < FRAME_LENGTH)
            begin
                waddr = r.wf * FRAME_LENGTH + r.wi;
                bank_copy[waddr]    = r.wv;
                bank_written[waddr] = 1'b1;
            end
        end
        else
        begin
            reads_done++;
            if (r.known)
                expected_samples.push_back(r.want);
            else
                expected_samples.push_back(predict_sample(locate_taps(r.ph, r.fp, r.wp)));
        end
    endtask

    // Unused fields of each item carry random junk.
    task automatic send_write(input int unsigned f, input int unsigned i, input sample_t v);
        stim_row_t r;
        r    = write_row(f, i, v);
        r.ph = phase_t'($urandom);
        r.fp = fpos_t'($urandom);
        r.wp = warp_t'($urandom);
        push_item(r);
    endtask

    // Write any neighbour not yet written before the read goes out.
    task automatic send_read(input stim_row_t r);
        taps_t t;
        t = locate_taps(r.ph, r.fp, r.wp);
        for (int k = 0; k < 4; k++)
        begin
            if (!bank_written[t.addr[k]])
            begin
                send_write(t.addr[k] / FRAME_LENGTH, t.addr[k] % FRAME_LENGTH,
                           random_sample());
                fills_done++;
            end
        end
        last_taps = t;
        r.wf = wframe_t'($urandom);
        r.wi = windex_t'($urandom);
        r.wv = sample_t'($urandom);
        push_item(r);
    endtask

    task automatic oscillator_run();
        phase_t      ph;
        phase_t      step;
        fpos_t       fp;
        warp_t       wp;
        int          len;
        int unsigned sel;
        ph   = phase_t'($urandom);
        step = phase_t'($urandom_range(32'h0040_0000));
        len  = $urandom_range(4, 16);
        fp   = ($urandom_range(3) == 0) ? fpos_t'($urandom_range(64000, 65535))
                                        : fpos_t'($urandom_range(65535));
        sel  = $urandom_range(2);
        if (sel == 0)
            wp = '0;
        else if (sel == 1)
            wp = warp_t'(int'($urandom_range(1023)) - 512);
        else
            wp = warp_t'($urandom);
        for (int n = 0; n < len; n++)
        begin
            send_read(read_row(ph, fp, wp, 1'b0, 0));
            ph = ph + step;
            fp = fp + fpos_t'($urandom_range(15));
        end
    endtask

    task automatic stray_write();
        int unsigned addr;
        if ($urandom_range(1) == 0)
            addr = last_taps.addr[$urandom_range(3)];
        else
            addr = $urandom_range(BANK_SIZE - 1);
        send_write(addr / FRAME_LENGTH, addr % FRAME_LENGTH, random_sample());
    endtask

    initial
    begin
        int src_mix [3];
        int snk_mix [3];
        int mode_end;
        int pick;
        src_mix = '{7, 67, 0};
        snk_mix = '{67, 7, 0};

        in_bus.valid          <= 1'b0;
        in_bus.command        <= CMD_READ;
        in_bus.phase          <= '0;
        in_bus.frame_position <= '0;
        in_bus.warp           <= '0;
        in_bus.write_frame    <= '0;
        in_bus.write_index    <= '0;
        in_bus.write_value    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = src_mix[0];
        snk_idle_pct = snk_mix[0];

        directed_rows = '{
            write_row(0, 0, 131071),
            write_row(0, 1, -5),
            write_row(1, 0, -131072),
            write_row(1, 1, 77),
            read_row(32'h0, 16'h0000, 16'sh0000, 1'b1, 131071),
            read_row(32'h0, 16'h0400, 16'sh0000, 1'b1, -131072),
            write_row(62, 0, -131072),
            write_row(63, 0, -131072),
            read_row(32'h0, 16'hFFFF, 16'sh0000, 1'b1, -131072),
            read_row(32'h0, 16'd64511, 16'sh0000, 1'b1, -131072),
            read_row(32'h0, 16'd64512, 16'sh0000, 1'b1, -131072),
            write_row(0, 2047, -131072),
            write_row(1, 2047, 131071),
            read_row(32'hFFFF_FFFF, 16'h0000, 16'sh0000, 1'b0, 0),
            read_row(32'h4000_0000, 16'h0200, 16'sh7FFF, 1'b0, 0),
            read_row(32'hC000_0000, 16'h7FFF, 16'sh8000, 1'b0, 0),
            read_row(32'h2AAA_AAAA, 16'h8123, 16'sh1234, 1'b0, 0),
            write_row(0, 0, 0),
            read_row(32'h0, 16'h0000, 16'sh0000, 1'b1, 0),
            write_row(63, 2047, -1),
            write_row(32, 1024, 65535),
            read_row(32'h8000_0000, 16'hF800, 16'shFFFF, 1'b0, 0),
            read_row(32'h5555_5555, 16'h8000, 16'sh4000, 1'b0, 0)
        };
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].cmd == CMD_WRITE)
                send_write(directed_rows[k].wf, directed_rows[k].wi, directed_rows[k].wv);
            else
                send_read(directed_rows[k]);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle_pct = src_mix[mode];
            snk_idle_pct = snk_mix[mode];
            if (mode == 2)
                hold_request = 1'b1;
            mode_end = items_done + MODE_ITEMS;
            while (items_done < mode_end)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    oscillator_run();
                else if (pick < 85)
                    send_read(read_row(phase_t'($urandom), fpos_t'($urandom),
                                       warp_t'($urandom), 1'b0, 0));
                else
                    stray_write();
            end
        end
        in_bus.valid <= 1'b0;

        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d writes (%0d to prime neighbours) and %0d reads, %0d samples checked,",
                 writes_done, fills_done, reads_done, samples_checked);
        $display("under three pacing mixes and one %0d-cycle output hold-off.", HOLD_CYCLES);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Output side: random back-pressure plus one long hold-off once requested.
    initial
    begin
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else
                out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        sample_t head;
        if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        begin
            if (expected_samples.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected sample, expected none, got %0d",
                         $time, out_bus.sample);
            end
            else
            begin
                head = expected_samples.pop_front();
                samples_checked++;
                if (out_bus.sample !== head)
                begin
                    failures++;
                    $display("%0t: sample mismatch, expected %0d, got %0d",
                             $time, head, out_bus.sample);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d samples still awaited", expected_samples.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/mwr_pkg.sv
src/mwr_if.sv
src/morphing_wavetable_read.sv
verif/morphing_wavetable_read_tb.sv
